@@ design/msw_pkg.sv @@
`timescale 1ns / 1ps

package msw_pkg;

  // Matrix and window limits
  localparam int ROW_W     = 10;
  localparam int COL_W     = 10;
  localparam int MAX_ROWS  = 1 << ROW_W;
  localparam int MAX_COLS  = 1 << COL_W;
  localparam int MAX_WIN_H = 4;
  localparam int MAX_WIN_W = 4;

  // Field and register widths
  localparam int ELEM_W     = 16;
  localparam int SUM_W      = 20;
  localparam int CSUM_W     = ELEM_W + $clog2(MAX_WIN_H);
  localparam int CFG_W      = 11;
  localparam int WIN_CFG_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int HIDX_W     = (MAX_WIN_H > 1) ? $clog2(MAX_WIN_H) : 1;
  localparam int WIDX_W     = (MAX_WIN_W > 1) ? $clog2(MAX_WIN_W) : 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_ROWS   = 3'd0,
    REG_MATRIX_COLS   = 3'd1,
    REG_WINDOW_HEIGHT = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3
  } reg_idx_t;

  // One window column, top row first
  typedef logic [MAX_WIN_H-1:0][ELEM_W-1:0] col_t;

  // Whole window, indexed [row][column]
  typedef logic [MAX_WIN_H-1:0][MAX_WIN_W-1:0][ELEM_W-1:0] win_t;

  // Result snapshot handed to the output sequencer
  typedef struct packed {
    logic                    found;
    logic signed [SUM_W-1:0] total;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    win_t                    elems;
  } snap_t;

endpackage

@@ design/msw_line_bank.sv @@
`timescale 1ns / 1ps

module msw_line_bank
  import msw_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  addr,
  input  logic [ELEM_W-1:0] wr_data,
  output logic [ELEM_W-1:0] rd_data
);

  logic [ELEM_W-1:0] mem [MAX_COLS];

  // Write the current row, read the old entry at the same column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

@@ design/msw_col_cell.sv @@
`timescale 1ns / 1ps

module msw_col_cell
  import msw_pkg::*;
(
  input  logic                     clk,
  input  logic                     shift,
  input  col_t                     col_in,
  input  logic signed [CSUM_W-1:0] csum_in,
  input  logic                     in_window,
  input  logic signed [SUM_W-1:0]  acc_in,
  output col_t                     col,
  output logic signed [CSUM_W-1:0] csum,
  output logic signed [SUM_W-1:0]  acc_out
);

  // Take the column from the neighbor on each shift
  always_ff @(posedge clk) begin
    if (shift) begin
      col  <= col_in;
      csum <= csum_in;
    end
  end

  // Add this column's sum to the window total when it lies inside the window
  assign acc_out = in_window ? acc_in + SUM_W'(csum) : acc_in;

endmodule

@@ design/msw_emitter.sv @@
`timescale 1ns / 1ps

module msw_emitter
  import msw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  snap_t                    snap,
  input  logic [HIDX_W-1:0]        p_last,
  input  logic [WIDX_W-1:0]        q_last,
  output logic                     can_load,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ELEM_W-1:0] window_element,
  output logic signed [SUM_W-1:0]  best_sum,
  output logic [ROW_W-1:0]         best_row,
  output logic [COL_W-1:0]         best_col,
  output logic                     found,
  output logic                     last
);

  snap_t             hold;
  logic [HIDX_W-1:0] a_cnt;
  logic [WIDX_W-1:0] b_cnt;
  logic              at_end;

  assign at_end   = !hold.found || (a_cnt == p_last && b_cnt == q_last);
  assign can_load = !out_valid || (out_ready && at_end);

  // Walk the held window row-major, one transaction per element
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      a_cnt     <= '0;
      b_cnt     <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      a_cnt     <= '0;
      b_cnt     <= '0;
    end else if (out_valid && out_ready) begin
      if (at_end) begin
        out_valid <= 1'b0;
      end else if (b_cnt == q_last) begin
        b_cnt <= '0;
        a_cnt <= a_cnt + 1'b1;
      end else begin
        b_cnt <= b_cnt + 1'b1;
      end
    end
  end

  // Hold the snapshot for the whole run of results
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= snap;
    end
  end

  assign window_element = hold.found ? $signed(hold.elems[a_cnt][b_cnt]) : '0;
  assign best_sum       = hold.found ? hold.total : '0;
  assign best_row       = hold.found ? hold.row : '0;
  assign best_col       = hold.found ? hold.col : '0;
  assign found          = hold.found;
  assign last           = at_end;

endmodule

@@ design/max_sum_window_finder.sv @@
`timescale 1ns / 1ps
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// input    | in_valid / in_ready    | element
// output   | out_valid / out_ready  | window_element, best_sum, best_row, best_col,
//          |                        | found, last
// config   | cfg_write              | cfg_index, cfg_data
//
// One element per cycle: a read stage on the line store banks, a shift into the
// column cell chain, then the window sum and best compare over the chain.
// After the final element of a matrix, results follow one per cycle while out_ready
// is high: window height times width of them, or one when nothing was found.
// A final element waits in the compare stage while the previous run's results
// are still being taken; this is the only case that holds back the input.
// Reset clears control only; line stores are not swept, since a window reads
// only entries written earlier in the same run.

module max_sum_window_finder
  import msw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ELEM_W-1:0] element,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ELEM_W-1:0] window_element,
  output logic signed [SUM_W-1:0]  best_sum,
  output logic [ROW_W-1:0]         best_row,
  output logic [COL_W-1:0]         best_col,
  output logic                     found,
  output logic                     last
);

  // Configuration
  logic [CFG_W-1:0]     matrix_rows;
  logic [CFG_W-1:0]     matrix_cols;
  logic [WIN_CFG_W-1:0] window_height;
  logic [WIN_CFG_W-1:0] window_width;
  logic                 cfg_hit;
  logic [ROW_W-1:0]     rows_last;
  logic [COL_W-1:0]     cols_last;
  logic [HIDX_W-1:0]    p_last;
  logic [WIDX_W-1:0]    q_last;

  // Input position
  logic [ROW_W-1:0]  row_pos;
  logic [COL_W-1:0]  col_pos;
  logic [HIDX_W-1:0] bank;
  logic              accept;
  logic              adv;
  logic              at_final;
  logic              win_ok;

  // Read stage
  logic [ELEM_W-1:0]       bank_rd [MAX_WIN_H];
  logic                    s1_valid;
  logic [ELEM_W-1:0]       s1_elem;
  logic [HIDX_W-1:0]       s1_bank;
  logic                    s1_win_ok;
  logic                    s1_final;
  logic [ROW_W-1:0]        s1_top;
  logic [COL_W-1:0]        s1_left;
  col_t                    new_col;
  logic signed [CSUM_W-1:0] csum_new;
  logic                    shift;

  // Cell chain
  col_t                     col_feed  [MAX_WIN_W];
  logic signed [CSUM_W-1:0] csum_feed [MAX_WIN_W];
  col_t                     cell_col  [MAX_WIN_W];
  logic signed [CSUM_W-1:0] cell_csum [MAX_WIN_W];
  logic signed [SUM_W-1:0]  acc       [MAX_WIN_W+1];
  logic signed [SUM_W-1:0]  wsum;

  // Compare stage
  logic             s2_valid;
  logic             s2_win_ok;
  logic             s2_final;
  logic [ROW_W-1:0] s2_top;
  logic [COL_W-1:0] s2_left;
  win_t             win_now;
  logic             improve;
  logic             eval;

  // Best so far
  logic signed [SUM_W-1:0] best_total;
  logic                    best_found;
  logic [ROW_W-1:0]        best_top_row;
  logic [COL_W-1:0]        best_left_col;
  win_t                    best_window;
  snap_t                   snap;
  logic                    em_can_load;

  // Decode register writes
  always_comb begin
    unique case (cfg_index)
      REG_MATRIX_ROWS, REG_MATRIX_COLS, REG_WINDOW_HEIGHT, REG_WINDOW_WIDTH: begin
        cfg_hit = cfg_write;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_rows   <= CFG_W'(3);
      matrix_cols   <= CFG_W'(3);
      window_height <= WIN_CFG_W'(2);
      window_width  <= WIN_CFG_W'(2);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MATRIX_ROWS:   matrix_rows   <= cfg_data;
        REG_MATRIX_COLS:   matrix_cols   <= cfg_data;
        REG_WINDOW_HEIGHT: window_height <= cfg_data[WIN_CFG_W-1:0];
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[WIN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes and keep them as last index
  always_comb begin
    if (matrix_rows == '0) begin
      rows_last = '0;
    end else if (matrix_rows > CFG_W'(MAX_ROWS)) begin
      rows_last = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_last = ROW_W'(matrix_rows - 1'b1);
    end
    if (matrix_cols == '0) begin
      cols_last = '0;
    end else if (matrix_cols > CFG_W'(MAX_COLS)) begin
      cols_last = COL_W'(MAX_COLS - 1);
    end else begin
      cols_last = COL_W'(matrix_cols - 1'b1);
    end
    if (window_height == '0) begin
      p_last = '0;
    end else if (window_height > WIN_CFG_W'(MAX_WIN_H)) begin
      p_last = HIDX_W'(MAX_WIN_H - 1);
    end else begin
      p_last = HIDX_W'(window_height - 1'b1);
    end
    if (window_width == '0) begin
      q_last = '0;
    end else if (window_width > WIN_CFG_W'(MAX_WIN_W)) begin
      q_last = WIDX_W'(MAX_WIN_W - 1);
    end else begin
      q_last = WIDX_W'(window_width - 1'b1);
    end
  end

  // Stall only when a final element meets a busy output sequencer
  assign adv      = !(s2_valid && s2_final && !em_can_load);
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  assign at_final = (row_pos == rows_last) && (col_pos == cols_last);
  assign win_ok   = (row_pos >= ROW_W'(p_last)) && (col_pos >= COL_W'(q_last));

  // Advance the raster position and the bank of the current row
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_pos <= '0;
      col_pos <= '0;
      bank    <= '0;
    end else if (accept) begin
      if (at_final) begin
        row_pos <= '0;
        col_pos <= '0;
        bank    <= '0;
      end else if (col_pos == cols_last) begin
        col_pos <= '0;
        row_pos <= row_pos + 1'b1;
        bank    <= (bank == HIDX_W'(MAX_WIN_H - 1)) ? '0 : bank + 1'b1;
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  // Line store banks, one per window row
  for (genvar k = 0; k < MAX_WIN_H; k++) begin : g_bank
    msw_line_bank u_bank (
      .clk     (clk),
      .wr_en   (accept && (bank == HIDX_W'(k))),
      .rd_en   (accept),
      .addr    (col_pos),
      .wr_data (element),
      .rd_data (bank_rd[k])
    );
  end

  // Read stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_elem   <= element;
      s1_bank   <= bank;
      s1_win_ok <= win_ok;
      s1_final  <= at_final;
      s1_top    <= row_pos - ROW_W'(p_last);
      s1_left   <= col_pos - COL_W'(q_last);
    end
  end

  // Assemble the new column: window row a comes from row r - (p_last - a)
  always_comb begin
    logic [HIDX_W-1:0] d;
    logic [HIDX_W-1:0] src;
    d        = '0;
    src      = '0;
    csum_new = '0;
    for (int a = 0; a < MAX_WIN_H; a++) begin
      if (HIDX_W'(a) > p_last) begin
        new_col[a] = '0;
      end else begin
        d = p_last - HIDX_W'(a);
        if (d == '0) begin
          new_col[a] = s1_elem;
        end else begin
          if (s1_bank >= d) begin
            src = s1_bank - d;
          end else begin
            src = HIDX_W'({1'b0, s1_bank} + (HIDX_W+1)'(MAX_WIN_H) - {1'b0, d});
          end
          new_col[a] = bank_rd[src];
        end
      end
      csum_new = csum_new + CSUM_W'($signed(new_col[a]));
    end
  end

  assign shift = adv && s1_valid;

  // Feed each cell from its left neighbor, the head from the read stage
  always_comb begin
    col_feed[0]  = new_col;
    csum_feed[0] = csum_new;
    for (int k = 1; k < MAX_WIN_W; k++) begin
      col_feed[k]  = cell_col[k-1];
      csum_feed[k] = cell_csum[k-1];
    end
  end

  assign acc[0] = '0;

  for (genvar k = 0; k < MAX_WIN_W; k++) begin : g_cell
    msw_col_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .col_in    (col_feed[k]),
      .csum_in   (csum_feed[k]),
      .in_window (WIDX_W'(k) <= q_last),
      .acc_in    (acc[k]),
      .col       (cell_col[k]),
      .csum      (cell_csum[k]),
      .acc_out   (acc[k+1])
    );
  end

  assign wsum = acc[MAX_WIN_W];

  // Compare stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      s2_win_ok <= s1_win_ok;
      s2_final  <= s1_final;
      s2_top    <= s1_top;
      s2_left   <= s1_left;
    end
  end

  // Reorder the chain into a row-major window: oldest cell is the left column
  always_comb begin
    for (int a = 0; a < MAX_WIN_H; a++) begin
      for (int b = 0; b < MAX_WIN_W; b++) begin
        win_now[a][b] = '0;
        for (int k = 0; k < MAX_WIN_W; k++) begin
          if (k + b == int'(q_last)) begin
            win_now[a][b] = cell_col[k][a];
          end
        end
      end
    end
  end

  assign eval    = adv && s2_valid;
  assign improve = s2_valid && s2_win_ok && (wsum > best_total);

  // Keep the earliest strictly larger window; drop it at the end of the run
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      best_total    <= '0;
      best_found    <= 1'b0;
      best_top_row  <= '0;
      best_left_col <= '0;
    end else if (eval) begin
      if (s2_final) begin
        best_total    <= '0;
        best_found    <= 1'b0;
        best_top_row  <= '0;
        best_left_col <= '0;
      end else if (improve) begin
        best_total    <= wsum;
        best_found    <= 1'b1;
        best_top_row  <= s2_top;
        best_left_col <= s2_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval && improve) begin
      best_window <= win_now;
    end
  end

  // Snapshot includes the final element's own window when it wins
  always_comb begin
    snap.found = improve || best_found;
    snap.total = improve ? wsum : best_total;
    snap.row   = improve ? s2_top : best_top_row;
    snap.col   = improve ? s2_left : best_left_col;
    snap.elems = improve ? win_now : best_window;
  end

  msw_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .load           (eval && s2_final),
    .snap           (snap),
    .p_last         (p_last),
    .q_last         (q_last),
    .can_load       (em_can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_element (window_element),
    .best_sum       (best_sum),
    .best_row       (best_row),
    .best_col       (best_col),
    .found          (found),
    .last           (last)
  );

endmodule

@@ design/msw_checker.sv @@
`timescale 1ns / 1ps

module msw_checker
  import msw_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [ELEM_W-1:0] window_element,
  input logic signed [SUM_W-1:0]  best_sum,
  input logic [ROW_W-1:0]         best_row,
  input logic [COL_W-1:0]         best_col,
  input logic                     found,
  input logic                     last
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_element)
      && $stable(best_sum) && $stable(last))
    else $error("result changed while stalled");

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // A not-found run is a single all-zero transaction
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last && best_sum == '0 && window_element == '0
      && best_row == '0 && best_col == '0)
    else $error("bad not-found result");

  // A kept window always beats zero
  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> $signed(best_sum) > 0)
    else $error("found with non-positive sum");

  // Results of one run follow back to back with the same sum
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && found && !last |=> out_valid && found && $stable(best_sum))
    else $error("window run broken");

endmodule

bind max_sum_window_finder msw_checker u_msw_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

package window_check_pkg;
  import msw_pkg::*;

  // One output transaction of the window finder
  typedef struct {
    logic signed [ELEM_W-1:0] elem;
    logic signed [SUM_W-1:0]  total;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     found;
    logic                     last;
  } window_result_t;

  // Tracks the best window of the current matrix and queues the window dump
  class best_window_model;
    logic [CFG_W-1:0]         rows_reg;
    logic [CFG_W-1:0]         cols_reg;
    logic [WIN_CFG_W-1:0]     height_reg;
    logic [WIN_CFG_W-1:0]     width_reg;
    logic signed [ELEM_W-1:0] line_rows [MAX_WIN_H][MAX_COLS];
    logic signed [ELEM_W-1:0] kept_window [MAX_WIN_H*MAX_WIN_W];
    int                       kept_total;
    bit                       kept_found;
    int                       kept_top;
    int                       kept_left;
    int                       row_pos;
    int                       col_pos;
    window_result_t           pending_results [$];
    int                       mismatches;
    int                       results_checked;
    int                       matrices_done;
    int                       empty_runs;

    function new();
      rows_reg = 3;
      cols_reg = 3;
      height_reg = 2;
      width_reg = 2;
      foreach (kept_window[k]) kept_window[k] = '0;
      restart_run();
    endfunction

    function void restart_run();
      kept_total = 0;
      kept_found = 0;
      kept_top = 0;
      kept_left = 0;
      row_pos = 0;
      col_pos = 0;
    endfunction

    // Zero means one, anything past the limit means the limit
    function int fit_size(int value, int limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
    endfunction

    function int matrix_elements();
      return fit_size(rows_reg, MAX_ROWS) * fit_size(cols_reg, MAX_COLS);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      case (index)
        REG_MATRIX_ROWS:   rows_reg = value;
        REG_MATRIX_COLS:   cols_reg = value;
        REG_WINDOW_HEIGHT: height_reg = value[WIN_CFG_W-1:0];
        REG_WINDOW_WIDTH:  width_reg = value[WIN_CFG_W-1:0];
        default:           return;
      endcase
      restart_run();
    endfunction

    // Store the element, sum the window it completes, dump on the final element
    function void absorb_element(logic signed [ELEM_W-1:0] value);
      int                       m, n, p, q, r, c;
      int                       top, left, sum, span;
      logic signed [ELEM_W-1:0] win [MAX_WIN_H*MAX_WIN_W];
      window_result_t           res;
      m = fit_size(rows_reg, MAX_ROWS);
      n = fit_size(cols_reg, MAX_COLS);
      p = fit_size(height_reg, MAX_WIN_H);
      q = fit_size(width_reg, MAX_WIN_W);
      r = (row_pos >= m) ? m - 1 : row_pos;
      c = (col_pos >= n) ? n - 1 : col_pos;
      line_rows[r % MAX_WIN_H][c] = value;
      win = kept_window;

      if (r + 1 >= p && c + 1 >= q) begin
        top = r + 1 - p;
        left = c + 1 - q;
        sum = 0;
        for (int a = 0; a < p; a++) begin
          for (int b = 0; b < q; b++) begin
            win[a*q + b] = line_rows[(top + a) % MAX_WIN_H][left + b];
            sum += win[a*q + b];
          end
        end
        // Strictly greater: the earliest window keeps a tie
        if (sum > kept_total) begin
          kept_total = sum;
          kept_found = 1;
          kept_top = top;
          kept_left = left;
          kept_window = win;
        end
      end

      if (r + 1 == m && c + 1 == n) begin
        matrices_done++;
        if (kept_found) begin
          span = p * q;
          for (int k = 0; k < span; k++) begin
            res.elem = kept_window[k];
            res.total = SUM_W'(kept_total);
            res.row = ROW_W'(kept_top);
            res.col = COL_W'(kept_left);
            res.found = 1'b1;
            res.last = (k + 1 == span);
            pending_results.push_back(res);
          end
        end else begin
          empty_runs++;
          res.elem = '0;
          res.total = '0;
          res.row = '0;
          res.col = '0;
          res.found = 1'b0;
          res.last = 1'b1;
          pending_results.push_back(res);
        end
        restart_run();
      end else if (c + 1 >= n) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    // Compare one output transaction with the oldest expectation
    function void check_result(window_result_t got);
      window_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting: window_element %0d, best_sum %0d",
               got.elem, got.total);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (got.elem !== want.elem) begin
        $error("window_element: expected %0d, got %0d", want.elem, got.elem);
        mismatches++;
      end
      if (got.total !== want.total) begin
        $error("best_sum: expected %0d, got %0d", want.total, got.total);
        mismatches++;
      end
      if (got.row !== want.row) begin
        $error("best_row: expected %0d, got %0d", want.row, got.row);
        mismatches++;
      end
      if (got.col !== want.col) begin
        $error("best_col: expected %0d, got %0d", want.col, got.col);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, got.found);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

module testbench;
  import msw_pkg::*;
  import window_check_pkg::*;

  localparam int                         DRAIN_CYCLES = 16;
  localparam int                         RANDOM_ITEMS = 380;
  localparam logic [CFG_IDX_W-1:0]       REG_UNUSED   = 3'd7;
  localparam logic signed [ELEM_W-1:0]   ELEM_MAX     = 16'sh7FFF;
  localparam logic signed [ELEM_W-1:0]   ELEM_MIN     = 16'sh8000;

  typedef enum int {
    DATA_FULL,
    DATA_SMALL,
    DATA_EXTREME,
    DATA_NEGATIVE,
    DATA_PEAK,
    DATA_FLOOR
  } data_style_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_MATRIX_ROWS;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [ELEM_W-1:0] element = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [ELEM_W-1:0] window_element;
  logic signed [SUM_W-1:0]  best_sum;
  logic [ROW_W-1:0]         best_row;
  logic [COL_W-1:0]         best_col;
  logic                     found;
  logic                     last;

  best_window_model model = new();
  bit                       sender_bursty = 0;
  int                       burst_left = 0;
  int                       elements_sent = 0;
  logic                     receiver_free = 1'b1;
  logic [15:0]              ready_mask = 16'hFFFF;
  logic [3:0]               ready_phase = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  max_sum_window_finder i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .element        (element),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_element (window_element),
    .best_sum       (best_sum),
    .best_row       (best_row),
    .best_col       (best_col),
    .found          (found),
    .last           (last)
  );

  // Check each output transaction, then advance the stall pattern
  always @(posedge clk) begin
    window_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.elem = window_element;
      got.total = best_sum;
      got.row = best_row;
      got.col = best_col;
      got.found = found;
      got.last = last;
      model.check_result(got);
    end
    out_ready <= receiver_free || ready_mask[ready_phase];
    ready_phase <= ready_phase + 4'd1;
    if (ready_phase == 4'hF) begin
      ready_mask <= ($urandom_range(0, 1) != 0) ? 16'($urandom & $urandom)
                                                : 16'($urandom | $urandom);
    end
  end

  function automatic logic signed [ELEM_W-1:0] next_element(data_style_t style);
    int v;
    case (style)
      DATA_SMALL:    v = int'($urandom_range(0, 8)) - 4;
      DATA_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      DATA_NEGATIVE: v = -int'($urandom_range(1, 32768));
      DATA_PEAK:     v = 32767;
      DATA_FLOOR:    v = -32768;
      default:       v = $urandom_range(0, 65535);
    endcase
    return ELEM_W'(v);
  endfunction

  function automatic int pick_window_size();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
  endfunction

  // Hold the element until accepted, then maybe drop valid for a gap
  task automatic send_element(input logic signed [ELEM_W-1:0] value);
    element <= value;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    model.absorb_element(value);
    elements_sent++;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_elements(input data_style_t style, input int count, input int tail_peaks);
    for (int i = 0; i < count; i++) begin
      send_element((i >= count - tail_peaks) ? ELEM_MAX : next_element(style));
    end
  endtask

  // Stop sending, wait out every expected result, then let the pipeline drain
  task automatic settle_block();
    in_valid <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    model.write_reg(index, value);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic signed [ELEM_W-1:0] mixed [9];
    int                       total;
    int                       part;
    int                       random_start;
    data_style_t              style;
    mixed = '{ELEM_MAX, ELEM_MIN, 16'sd1, 16'sd0, -16'sd1,
              16'sd16384, -16'sd16385, 16'sd2, ELEM_MAX};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: 3x3 matrix, 2x2 window
    foreach (mixed[i]) send_element(mixed[i]);
    // Equal sums everywhere: the top-left window must win
    repeat (9) send_element(16'sd1);

    // Window taller than the matrix: nothing can be found
    settle_block();
    set_register(REG_MATRIX_ROWS, 1);
    repeat (3) send_element(ELEM_MAX);

    // 1x1 matrix and window: zero sum, negative sum, then a hit
    settle_block();
    set_register(REG_MATRIX_COLS, 1);
    set_register(REG_WINDOW_HEIGHT, 1);
    set_register(REG_WINDOW_WIDTH, 1);
    send_element(16'sd0);
    send_element(ELEM_MIN);
    send_element(16'sd7);

    // Random phases: new sizes, a few matrices each, varied flow control
    random_start = elements_sent;
    while (elements_sent - random_start < RANDOM_ITEMS) begin
      settle_block();
      set_register(REG_MATRIX_ROWS,
                   CFG_W'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 7)));
      set_register(REG_MATRIX_COLS,
                   CFG_W'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9)));
      set_register(REG_WINDOW_HEIGHT, CFG_W'(pick_window_size()));
      set_register(REG_WINDOW_WIDTH, CFG_W'(pick_window_size()));
      sender_bursty = ($urandom_range(0, 3) != 0);
      receiver_free <= ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        total = model.matrix_elements();
        style = data_style_t'($urandom_range(DATA_FULL, DATA_FLOOR));
        part = (total > 1) ? $urandom_range(1, total - 1) : 0;
        case ($urandom_range(0, 9))
          0: begin
            // Abandon the matrix partway; a register write restarts the run
            send_elements(style, part, 0);
            settle_block();
            set_register(REG_WINDOW_WIDTH, CFG_W'(pick_window_size()));
          end
          1: begin
            // Write past the register list partway; the matrix carries on
            send_elements(style, part, 0);
            settle_block();
            set_register(REG_UNUSED, CFG_W'($urandom));
            send_elements(style, total - part, 0);
          end
          default: begin
            send_elements(style, total, 0);
            if ($urandom_range(0, 2) == 0) settle_block();
          end
        endcase
      end
    end

    // Full 4x4 window at the largest and smallest sums, bursty sender, slow receiver
    sender_bursty = 1;
    receiver_free <= 1'b0;
    settle_block();
    set_register(REG_MATRIX_ROWS, 4);
    set_register(REG_MATRIX_COLS, 4);
    set_register(REG_WINDOW_HEIGHT, 4);
    set_register(REG_WINDOW_WIDTH, 4);
    send_elements(DATA_PEAK, 16, 0);
    send_elements(DATA_FLOOR, 16, 0);

    settle_block();
    $display("Sent %0d elements over %0d matrices; checked %0d results, %0d runs found nothing.",
             elements_sent, model.matrices_done, model.results_checked, model.empty_runs);
    $display("Windows 1x1 to 4x4, out-of-range sizes, mid-matrix restarts, full-scale sums.");
    if (model.mismatches == 0 && model.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
